FILE: rtl/tlpt_pkg.sv
package tlpt_pkg;

   localparam int TABLE_SLOTS = 16;
   localparam int DIR_COUNT   = 1024;

   localparam int ADDR_W   = 32;
   localparam int DIR_W    = 10;
   localparam int IDX_W    = 10;
   localparam int OFF_W    = 12;
   localparam int FRAME_W  = ADDR_W - OFF_W;
   localparam int ENTRIES_PER_TABLE = 1 << IDX_W;

   localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W      = $clog2(TABLE_SLOTS + 1);
   localparam int PAGE_AW    = SLOT_W + IDX_W;
   localparam int PAGE_DEPTH = TABLE_SLOTS * ENTRIES_PER_TABLE;

   // request codes
   localparam logic [1:0] REQ_TRANSLATE = 2'd0;
   localparam logic [1:0] REQ_MAP       = 2'd1;
   localparam logic [1:0] REQ_UNMAP     = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_MISALIGNED = 2'd1;
   localparam logic [1:0] STATUS_NO_SLOT    = 2'd2;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [ADDR_W-1:0] virt_addr;
      logic [ADDR_W-1:0] phys_addr;
      logic              allow_write;
      logic              allow_user;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0] phys_out;
      logic              hit;
      logic [1:0]        status;
   } rsp_payload_type;

   typedef struct packed {
      logic              present;
      logic              write;
      logic              user;
      logic [SLOT_W-1:0] slot;
   } dir_entry_type;

   typedef struct packed {
      logic               present;
      logic               write;
      logic               user;
      logic [FRAME_W-1:0] frame;
   } page_entry_type;

   typedef struct packed {
      logic ready;
      logic done;
   } eng_status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_DIR,
      S_PAGE
   } state_type;

endpackage

FILE: rtl/tlpt_engine.sv
module tlpt_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  tlpt_pkg::req_payload_type req_data,
   input  logic                     out_free,
   output tlpt_pkg::eng_status_type  eng_status,
   output tlpt_pkg::rsp_payload_type result
);
   import tlpt_pkg::*;

   dir_entry_type  dir_mem  [DIR_COUNT];
   page_entry_type page_mem [PAGE_DEPTH];

   state_type       state_ff, state_in;
   logic [PAGE_AW-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] next_free_ff, next_free_in;
   req_payload_type cur_ff;
   dir_entry_type   dir_rd_ff;
   page_entry_type  page_rd_ff;

   logic             dir_re, dir_we;
   logic [DIR_W-1:0] dir_raddr, dir_waddr;
   dir_entry_type    dir_wdata;
   logic             page_re, page_we;
   logic [PAGE_AW-1:0] page_addr;
   page_entry_type   page_wdata;

   logic [SLOT_W-1:0] slot_sel;
   logic [IDX_W-1:0]  tbl_idx;
   logic              misaligned;
   logic              no_slot;

   assign tbl_idx    = cur_ff.virt_addr[OFF_W +: IDX_W];
   assign slot_sel   = dir_rd_ff.present ? dir_rd_ff.slot : next_free_ff[SLOT_W-1:0];
   assign misaligned = (cur_ff.virt_addr[OFF_W-1:0] != '0) ||
                       (cur_ff.phys_addr[OFF_W-1:0] != '0);
   assign no_slot    = !dir_rd_ff.present && (next_free_ff >= CNT_W'(TABLE_SLOTS));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      next_free_in = next_free_ff;
      dir_re       = 1'b0;
      dir_raddr    = req_data.virt_addr[ADDR_W-1 -: DIR_W];
      dir_we       = 1'b0;
      dir_waddr    = cur_ff.virt_addr[ADDR_W-1 -: DIR_W];
      dir_wdata    = '0;
      page_re      = 1'b0;
      page_we      = 1'b0;
      page_addr    = {slot_sel, tbl_idx};
      page_wdata   = '0;
      eng_status.ready = (state_ff == S_IDLE);
      eng_status.done  = 1'b0;
      result       = '0;

      case (state_ff)
         S_CLEAR: begin
            // slots are never reused, so one pass leaves every table slot clear
            dir_we    = 1'b1;
            dir_waddr = clr_ff[DIR_W-1:0];
            page_we   = 1'b1;
            page_addr = clr_ff;
            clr_in    = clr_ff + PAGE_AW'(1);
            if (clr_ff == PAGE_AW'(PAGE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               dir_re   = 1'b1;
               state_in = S_DIR;
            end
         end
         S_DIR: begin
            if (cur_ff.req_type == REQ_TRANSLATE && dir_rd_ff.present) begin
               page_re  = 1'b1;
               state_in = S_PAGE;
            end else if (out_free) begin
               eng_status.done = 1'b1;
               state_in        = S_IDLE;
               case (cur_ff.req_type)
                  REQ_MAP: begin
                     if (misaligned) begin
                        result.status = STATUS_MISALIGNED;
                     end else if (no_slot) begin
                        result.status = STATUS_NO_SLOT;
                     end else begin
                        if (!dir_rd_ff.present) begin
                           // first use of this directory entry: claim a table slot
                           dir_we             = 1'b1;
                           dir_wdata.present  = 1'b1;
                           dir_wdata.write    = cur_ff.allow_write;
                           dir_wdata.user     = cur_ff.allow_user;
                           dir_wdata.slot     = next_free_ff[SLOT_W-1:0];
                           next_free_in       = next_free_ff + CNT_W'(1);
                        end
                        page_we            = 1'b1;
                        page_wdata.present = 1'b1;
                        page_wdata.write   = cur_ff.allow_write;
                        page_wdata.user    = cur_ff.allow_user;
                        page_wdata.frame   = cur_ff.phys_addr[ADDR_W-1:OFF_W];
                     end
                  end
                  REQ_UNMAP: begin
                     page_we = dir_rd_ff.present;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PAGE: begin
            if (out_free) begin
               eng_status.done = 1'b1;
               state_in        = S_IDLE;
               if (page_rd_ff.present) begin
                  result.phys_out = {page_rd_ff.frame, cur_ff.virt_addr[OFF_W-1:0]};
                  result.hit      = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         next_free_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_free_ff <= next_free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && state_ff == S_IDLE) begin
         cur_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
      if (dir_re) begin
         dir_rd_ff <= dir_mem[dir_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (page_we) begin
         page_mem[page_addr] <= page_wdata;
      end
      if (page_re) begin
         page_rd_ff <= page_mem[page_addr];
      end
   end

endmodule

FILE: rtl/two_level_page_table_core.sv
// A translate with a present directory entry does the directory read and then the dependent
// page-table read before loading the response register; every other request loads it after
// the directory read alone. One request is in flight at a time, so a new request is not taken
// until the last one has loaded the response register; rsp_stall holds the engine further.
// After reset the directory and page memories are cleared, with req_stall held high
// throughout. Table slots are handed out in order and never returned.
module two_level_page_table_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tlpt_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tlpt_pkg::rsp_payload_type rsp_payload
);
   import tlpt_pkg::*;

   eng_status_type  eng_status;
   rsp_payload_type eng_result;
   logic            start;
   logic            out_free;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;

   assign req_stall = !eng_status.ready;
   assign start     = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   tlpt_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_payload),
      .out_free   (out_free),
      .eng_status (eng_status),
      .result     (eng_result)
   );

   // response register holds until taken
   assign rsp_valid_in = eng_status.done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_status.done) begin
         rsp_data_ff <= eng_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

FILE: tb/tb_two_level_page_table_core.sv
module tb_two_level_page_table_core;
   import tlpt_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 1200;
   localparam int QUIET_TAIL      = 150;
   localparam int POOL_SIZE       = 24;
   localparam int CYCLE_LIMIT     = 200000;

   class translation_scoreboard;
      dir_entry_type   dir_table [DIR_COUNT];
      page_entry_type  page_store [PAGE_DEPTH];
      int              slots_used;
      rsp_payload_type expected_responses [$];
      int              error_count;
      int              checked_count;
      int              hit_count;
      int              miss_count;
      int              misaligned_count;
      int              no_slot_count;

      function new();
         foreach (dir_table[i]) dir_table[i] = '0;
         foreach (page_store[i]) page_store[i] = '0;
         slots_used       = 0;
         error_count      = 0;
         checked_count    = 0;
         hit_count        = 0;
         miss_count       = 0;
         misaligned_count = 0;
         no_slot_count    = 0;
      endfunction

      function rsp_payload_type predict_response(req_payload_type r);
         rsp_payload_type  want;
         logic [DIR_W-1:0] di;
         logic [IDX_W-1:0] ti;
         logic [SLOT_W-1:0] fresh;
         logic [PAGE_AW-1:0] pos;
         int i;
         want = '0;
         di = r.virt_addr[ADDR_W-1 -: DIR_W];
         ti = r.virt_addr[OFF_W +: IDX_W];
         case (r.req_type)
            REQ_TRANSLATE: begin
               if (dir_table[di].present) begin
                  pos = {dir_table[di].slot, ti};
                  if (page_store[pos].present) begin
                     want.phys_out = {page_store[pos].frame, r.virt_addr[OFF_W-1:0]};
                     want.hit      = 1'b1;
                  end
               end
            end
            REQ_MAP: begin
               if (r.virt_addr[OFF_W-1:0] != '0 || r.phys_addr[OFF_W-1:0] != '0) begin
                  want.status = STATUS_MISALIGNED;
               end else if (!dir_table[di].present && slots_used >= TABLE_SLOTS) begin
                  want.status = STATUS_NO_SLOT;
               end else begin
                  if (!dir_table[di].present) begin
                     fresh = SLOT_W'(slots_used);
                     for (i = 0; i < ENTRIES_PER_TABLE; i++)
                        page_store[{fresh, IDX_W'(i)}] = '0;
                     dir_table[di] = '{present: 1'b1, write: r.allow_write,
                                       user: r.allow_user, slot: fresh};
                     slots_used++;
                  end
                  pos = {dir_table[di].slot, ti};
                  page_store[pos] = '{present: 1'b1, write: r.allow_write,
                                      user: r.allow_user,
                                      frame: r.phys_addr[ADDR_W-1:OFF_W]};
               end
            end
            REQ_UNMAP: begin
               if (dir_table[di].present) begin
                  pos = {dir_table[di].slot, ti};
                  page_store[pos] = '0;
               end
            end
            default: ;
         endcase
         return want;
      endfunction

      function void note_request(req_payload_type r);
         rsp_payload_type want;
         want = predict_response(r);
         expected_responses.push_back(want);
         if (r.req_type == REQ_TRANSLATE) begin
            if (want.hit) hit_count++;
            else miss_count++;
         end
         if (want.status == STATUS_MISALIGNED) misaligned_count++;
         if (want.status == STATUS_NO_SLOT) no_slot_count++;
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_responses.size() == 0) begin
            $display("%0t: response with nothing outstanding, expected none, got %h/%b/%0d",
                     $time, got.phys_out, got.hit, got.status);
            error_count++;
            return;
         end
         want = expected_responses.pop_front();
         checked_count++;
         if (got.phys_out !== want.phys_out) begin
            $display("%0t: phys_out mismatch, expected %h, got %h",
                     $time, want.phys_out, got.phys_out);
            error_count++;
         end
         if (got.hit !== want.hit) begin
            $display("%0t: hit mismatch, expected %b, got %b", $time, want.hit, got.hit);
            error_count++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
            error_count++;
         end
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   translation_scoreboard board = new();
   int          idle_pct;
   int          stall_pct;
   int          stall_run;
   int          cycle_count;
   int unsigned dir_pool [POOL_SIZE];

   two_level_page_table_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run--;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_stall <= 1'b1;
         stall_run = $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_payload);
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input req_payload_type item);
      req_payload <= item;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(item);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [1:0] kind, input logic [ADDR_W-1:0] va,
                              input logic [ADDR_W-1:0] pa, input logic wr, input logic us);
      req_payload_type item;
      item = '{req_type: kind, virt_addr: va, phys_addr: pa,
               allow_write: wr, allow_user: us};
      send_request(item);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_for_drain();
      while (board.expected_responses.size() != 0) @(negedge clock);
   endtask

   function automatic req_payload_type random_request();
      req_payload_type  item;
      int unsigned      roll;
      int unsigned      pick;
      logic [DIR_W-1:0] di;
      logic [IDX_W-1:0] ti;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      di = (pick < 95) ? DIR_W'(dir_pool[$urandom_range(0, POOL_SIZE-1)]) : DIR_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 70) ti = IDX_W'($urandom_range(0, 15));
      else if (pick < 85) ti = IDX_W'($urandom);
      else ti = pick[0] ? '1 : '0;
      item.virt_addr   = {di, ti, OFF_W'($urandom)};
      item.phys_addr   = $urandom;
      item.allow_write = 1'($urandom_range(0, 1));
      item.allow_user  = 1'($urandom_range(0, 1));
      if (roll < 40) begin
         item.req_type = REQ_TRANSLATE;
      end else if (roll < 75) begin
         item.req_type = REQ_MAP;
         item.virt_addr[OFF_W-1:0] = '0;
         item.phys_addr[OFF_W-1:0] = '0;
      end else if (roll < 85) begin
         item.req_type = REQ_MAP;
         pick = $urandom_range(0, 2);
         if (pick == 0) item.virt_addr[OFF_W-1:0] = '0;
         if (pick == 1) item.phys_addr[OFF_W-1:0] = '0;
         if (item.virt_addr[OFF_W-1:0] == '0 && item.phys_addr[OFF_W-1:0] == '0)
            item.phys_addr[0] = 1'b1;
      end else if (roll < 95) begin
         item.req_type = REQ_UNMAP;
      end else if (roll < 98) begin
         item.req_type = REQ_UNUSED;
      end else begin
         item.req_type  = REQ_TRANSLATE;
         item.virt_addr = $urandom;
      end
      return item;
   endfunction

   initial begin
      idle_pct  = 0;
      stall_pct = 20;
      stall_run = 0;
      dir_pool[0] = 0;
      dir_pool[1] = DIR_COUNT - 1;
      for (int i = 2; i < POOL_SIZE; i++) dir_pool[i] = $urandom_range(0, DIR_COUNT - 1);

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part
      send_fields(REQ_TRANSLATE, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
      send_fields(REQ_TRANSLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_fields(REQ_UNMAP,     32'h1234_5678, 32'h0000_0000, 1'b0, 1'b0);
      send_fields(REQ_MAP,       32'h0000_0000, 32'hFFFF_F000, 1'b1, 1'b1);
      send_fields(REQ_TRANSLATE, 32'h0000_0FFF, 32'h0000_0000, 1'b0, 1'b0);
      send_fields(REQ_TRANSLATE, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
      send_fields(REQ_MAP,       32'h0040_0001, 32'h0000_0000, 1'b1, 1'b0);
      send_fields(REQ_MAP,       32'h0040_0000, 32'h0000_0800, 1'b0, 1'b1);
      send_fields(REQ_TRANSLATE, 32'h0040_0000, 32'h0000_0000, 1'b0, 1'b0);
      send_fields(REQ_MAP,       32'hFFFF_F000, 32'h0000_0000, 1'b0, 1'b0);
      send_fields(REQ_TRANSLATE, 32'hFFFF_FABC, 32'h0000_0000, 1'b0, 1'b0);
      // second map under a present directory keeps its flags
      send_fields(REQ_MAP,       32'h003F_F000, 32'h1234_5000, 1'b0, 1'b1);
      send_fields(REQ_TRANSLATE, 32'h003F_F123, 32'h0000_0000, 1'b0, 1'b0);
      // unmap ignores the offset bits
      send_fields(REQ_UNMAP,     32'h003F_F7FF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_fields(REQ_TRANSLATE, 32'h003F_F000, 32'h0000_0000, 1'b0, 1'b0);
      send_fields(REQ_UNUSED,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_fields(REQ_MAP,       32'h0000_0000, 32'hABCD_E000, 1'b0, 1'b1);
      send_fields(REQ_TRANSLATE, 32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0);
      // entry never mapped in an allocated slot reads back as absent
      send_fields(REQ_TRANSLATE, 32'h0000_5000, 32'h0000_0000, 1'b0, 1'b0);
      req_valid <= 1'b0;
      wait_for_drain();

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 100 == 0) begin
            if (n >= RANDOM_REQUESTS - QUIET_TAIL) begin
               idle_pct  = 0;
               stall_pct = 0;
            end else begin
               idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
               stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            end
         end
         if (n == RANDOM_REQUESTS / 2) begin
            req_valid <= 1'b0;
            wait_for_drain();
         end
         send_request(random_request());
         if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            pause_sender($urandom_range(1, 5));
      end
      req_valid <= 1'b0;

      wait_for_drain();
      repeat (10) @(negedge clock);
      $display("Checked %0d responses: %0d translate hits, %0d translate misses,",
               board.checked_count, board.hit_count, board.miss_count);
      $display("%0d misaligned maps, %0d maps refused, %0d of %0d table slots allocated",
               board.misaligned_count, board.no_slot_count, board.slots_used, TABLE_SLOTS);
      if (board.error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
